// File: rtl/core/addressable_led_serial_encoder_macros.svh
// Assertion macros shared by the LED strip serial encoder RTL.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef ADDRESSABLE_LED_SERIAL_ENCODER_MACROS_SVH
`define ADDRESSABLE_LED_SERIAL_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALED_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/aled_pkg.sv
// Shared types and constants of the LED strip serial encoder.
// No dependencies; imported by every module of the block except aled_ram.
package aled_pkg;

  localparam int PIX_W     = 24;
  localparam int BITPOS_W  = 5;
  localparam int TICK_W    = 16;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_START = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  localparam logic [2:0] REG_BIT_PERIOD  = 3'd0;
  localparam logic [2:0] REG_ZERO_HIGH   = 3'd1;
  localparam logic [2:0] REG_ONE_HIGH    = 3'd2;
  localparam logic [2:0] REG_GUARD       = 3'd3;
  localparam logic [2:0] REG_PIXEL_COUNT = 3'd4;

  localparam logic [11:0] RST_BIT_PERIOD  = 12'd52;
  localparam logic [11:0] RST_ZERO_HIGH   = 12'd10;
  localparam logic [11:0] RST_ONE_HIGH    = 12'd27;
  localparam logic [15:0] RST_GUARD       = 16'd2310;
  localparam logic [6:0]  RST_PIXEL_COUNT = 7'd40;

  typedef struct packed {
    logic [11:0] bit_period;
    logic [11:0] zero_high;
    logic [11:0] one_high;
    logic [15:0] guard;
    logic [6:0]  pixel_count;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } res_t;

endpackage

// File: rtl/core/addressable_led_serial_encoder.sv
// Top level of the single-wire addressable LED strip serial encoder.
// Throughput: one item per cycle while in_stall is low; the pixel store RAM is read
// every cycle at the next pixel position and a one-entry write forward covers collisions.
// Reset clears all control state and the store's per-entry valid bits directly, so no
// clearing pass follows; depends on aled_pkg and the submodules.
`include "addressable_led_serial_encoder_macros.svh"

module addressable_led_serial_encoder #(
  parameter int MAX_PIXELS     = 64,
  parameter int BITS_PER_PIXEL = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [5:0]                  in_pixel_index,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_blue,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_line_level,
  output logic                        out_busy_res,
  output logic                        out_accepted,
  output logic                        out_frame_done,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [aled_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [aled_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [aled_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import aled_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_out;
  logic accept;

  assign accept = in_valid && !in_stall;

  aled_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  aled_engine #(
    .MAX_PIXELS     (MAX_PIXELS),
    .BITS_PER_PIXEL (BITS_PER_PIXEL)
  ) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (accept),
    .item_kind        (in_kind),
    .item_pixel_index (in_pixel_index),
    .item_green       (in_green),
    .item_red         (in_red),
    .item_blue        (in_blue),
    .cfg              (cfg),
    .res              (res)
  );

  aled_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .din       (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_out)
  );

  assign out_line_level = res_out.line_level;
  assign out_busy_res   = res_out.busy_res;
  assign out_accepted   = res_out.accepted;
  assign out_frame_done = res_out.frame_done;

  `ALED_ASSERT_SAME(a_done_idle, out_valid && out_frame_done, !out_busy_res, "frame done while busy")
  `ALED_ASSERT_SAME(a_refuse_busy, out_valid && !out_accepted, out_busy_res, "start refused while idle")
  `ALED_ASSERT_SAME(a_line_busy, out_valid && out_line_level, out_busy_res, "line high while idle")
  `ALED_ASSERT_SAME(a_skid_order, in_stall, out_valid, "skid entry held without output entry")

endmodule

// File: rtl/core/aled_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the address written at the same edge returns the old data.
module aled_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/aled_cfg.sv
// APB-style configuration registers of the LED strip serial encoder.
// Depends on aled_pkg for the register indexes, reset values and cfg_t.
module aled_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aled_pkg::CFG_AW-1:0]   paddr,
  input  logic [aled_pkg::CFG_DW-1:0]   pwdata,
  output logic [aled_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output aled_pkg::cfg_t                cfg
);
  import aled_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_period  <= RST_BIT_PERIOD;
      cfg_r.zero_high   <= RST_ZERO_HIGH;
      cfg_r.one_high    <= RST_ONE_HIGH;
      cfg_r.guard       <= RST_GUARD;
      cfg_r.pixel_count <= RST_PIXEL_COUNT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BIT_PERIOD:  cfg_r.bit_period  <= pwdata[11:0];
        REG_ZERO_HIGH:   cfg_r.zero_high   <= pwdata[11:0];
        REG_ONE_HIGH:    cfg_r.one_high    <= pwdata[11:0];
        REG_GUARD:       cfg_r.guard       <= pwdata[15:0];
        REG_PIXEL_COUNT: cfg_r.pixel_count <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BIT_PERIOD:  prdata = {20'd0, cfg_r.bit_period};
      REG_ZERO_HIGH:   prdata = {20'd0, cfg_r.zero_high};
      REG_ONE_HIGH:    prdata = {20'd0, cfg_r.one_high};
      REG_GUARD:       prdata = {16'd0, cfg_r.guard};
      REG_PIXEL_COUNT: prdata = {25'd0, cfg_r.pixel_count};
      default:         prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/aled_obuf.sv
// Two-entry result buffer: an output register backed by a skid register.
// Depends on aled_pkg for res_t.
module aled_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  aled_pkg::res_t din,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output aled_pkg::res_t dout
);
  import aled_pkg::*;

  logic main_v_r;
  logic skid_v_r;
  res_t main_r;
  res_t skid_r;
  logic take;

  assign take      = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign dout      = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (main_v_r && !take) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end else if (take) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_v_r && !take) begin
        skid_r <= din;
      end else begin
        main_r <= din;
      end
    end
  end

endmodule

// File: rtl/core/aled_engine.sv
// Frame engine: pixel store in a RAM with write forwarding, and the bit timer.
// Depends on aled_pkg and aled_ram.
module aled_engine #(
  parameter int MAX_PIXELS     = 64,
  parameter int BITS_PER_PIXEL = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  logic [1:0]     item_kind,
  input  logic [5:0]     item_pixel_index,
  input  logic [7:0]     item_green,
  input  logic [7:0]     item_red,
  input  logic [7:0]     item_blue,
  input  aled_pkg::cfg_t cfg,
  output aled_pkg::res_t res
);
  import aled_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = ($clog2(MAX_PIXELS + 1) > 7) ? $clog2(MAX_PIXELS + 1) : 7;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SEND  = 2'd1,
    PH_GUARD = 2'd2
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [BITPOS_W-1:0] bitpos_r, bitpos_nxt;
  logic [AW-1:0]       pixpos_r, pixpos_nxt;
  logic                line_r, line_nxt;
  logic [MAX_PIXELS-1:0] valid_r;
  logic                fwd_v_r;
  logic [AW-1:0]       fwd_addr_r;
  logic [PIX_W-1:0]    fwd_data_r;

  kind_t               kind;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [PIX_W-1:0]    wr_data;
  logic [PIX_W-1:0]    rdata;
  logic [PIX_W-1:0]    cur_word;
  logic [31:0]         word_ext;
  logic [BITPOS_W-1:0] bit_sel;
  logic                cur_bit;
  logic [11:0]         high;
  logic [11:0]         period;
  logic [TICK_W-1:0]   guard;
  logic [TICK_W-1:0]   tick_inc;
  logic [CW-1:0]       pix_cnt;
  logic [CW-1:0]       frame_pix;
  logic                bit_last;
  logic                pixel_last;
  logic                acc;
  logic                done;

  assign kind    = kind_t'(item_kind);
  assign wr_en   = item_valid && (kind == KIND_SET || kind == KIND_CLEAR) &&
                   (CW'(item_pixel_index) < CW'(MAX_PIXELS));
  assign wr_addr = AW'(item_pixel_index);
  assign wr_data = (kind == KIND_SET) ? {item_green, item_red, item_blue} : '0;

  aled_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (pixpos_nxt),
    .rdata (rdata)
  );

  always_comb begin
    if (fwd_v_r && fwd_addr_r == pixpos_r) begin
      cur_word = fwd_data_r;
    end else if (valid_r[pixpos_r]) begin
      cur_word = rdata;
    end else begin
      cur_word = '0;
    end
  end

  assign word_ext = 32'(cur_word);
  assign bit_sel  = BITPOS_W'(BITS_PER_PIXEL - 1) - bitpos_r;
  assign cur_bit  = word_ext[bit_sel];

  assign high      = cur_bit ? cfg.one_high : cfg.zero_high;
  assign period    = (cfg.bit_period == '0) ? 12'd1 : cfg.bit_period;
  assign guard     = (cfg.guard == '0) ? 16'd1 : cfg.guard;
  assign tick_inc  = tick_r + 1'b1;
  assign pix_cnt   = CW'(cfg.pixel_count);
  assign frame_pix = (pix_cnt == '0) ? CW'(1) :
                     (pix_cnt > CW'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : pix_cnt;
  assign bit_last   = (bitpos_r == BITPOS_W'(BITS_PER_PIXEL - 1));
  assign pixel_last = ((CW'(pixpos_r) + 1'b1) >= frame_pix);

  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bitpos_nxt = bitpos_r;
    pixpos_nxt = pixpos_r;
    line_nxt   = line_r;
    acc        = 1'b1;
    done       = 1'b0;
    if (item_valid) begin
      unique case (kind)
        KIND_SET, KIND_CLEAR: begin
        end
        KIND_START: begin
          if (phase_r != PH_IDLE) begin
            acc = 1'b0;
          end else begin
            phase_nxt  = PH_SEND;
            tick_nxt   = '0;
            bitpos_nxt = '0;
            pixpos_nxt = '0;
          end
        end
        KIND_TICK: begin
          unique case (phase_r)
            PH_SEND: begin
              line_nxt = (tick_r < TICK_W'(high));
              if (tick_inc >= TICK_W'(period)) begin
                tick_nxt = '0;
                if (bit_last) begin
                  bitpos_nxt = '0;
                  if (pixel_last) begin
                    pixpos_nxt = '0;
                    phase_nxt  = PH_GUARD;
                  end else begin
                    pixpos_nxt = pixpos_r + 1'b1;
                  end
                end else begin
                  bitpos_nxt = bitpos_r + 1'b1;
                end
              end else begin
                tick_nxt = tick_inc;
              end
            end
            PH_GUARD: begin
              line_nxt = 1'b0;
              if (tick_inc >= guard) begin
                tick_nxt  = '0;
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end else begin
                tick_nxt = tick_inc;
              end
            end
            default: begin
              line_nxt = 1'b0;
            end
          endcase
        end
      endcase
    end
  end

  assign res.line_level = line_nxt;
  assign res.busy_res   = (phase_nxt != PH_IDLE);
  assign res.accepted   = acc;
  assign res.frame_done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= '0;
      bitpos_r <= '0;
      pixpos_r <= '0;
      line_r   <= 1'b0;
      valid_r  <= '0;
      fwd_v_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bitpos_r <= bitpos_nxt;
      pixpos_r <= pixpos_nxt;
      line_r   <= line_nxt;
      fwd_v_r  <= wr_en;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
  end

endmodule

// File: tb/led_line_checker.sv
`timescale 1ns / 1ps
// Checker for the LED strip serial encoder: tracks register writes, predicts the result of
// every accepted item and compares it with the result port. Depends on aled_pkg only.
module led_line_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [5:0]                  in_pixel_index,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_blue,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_line_level,
  input  logic                        out_busy_res,
  input  logic                        out_accepted,
  input  logic                        out_frame_done,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [aled_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [aled_pkg::CFG_DW-1:0] cfg_pwdata,
  input  logic [aled_pkg::CFG_DW-1:0] cfg_prdata,
  input  logic                        cfg_pready,
  output int                          fail_cnt,
  output int                          waiting_cnt,
  output int                          frames_latched
);
  import aled_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int PIXEL_BITS  = 24;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEND,
    PH_GUARD
  } phase_t;

  logic [23:0] color_store [STORE_DEPTH];
  phase_t      phase_q;
  logic [15:0] tick_q;
  logic [4:0]  bit_q;
  logic [5:0]  pix_q;
  logic        line_q;
  cfg_t        regs_q;
  res_t        line_states_due [$];

  initial begin
    fail_cnt = 0;
    waiting_cnt = 0;
    frames_latched = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_cnt < 100) begin
      $display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
    end
    fail_cnt++;
  endtask

  task automatic clear_model();
    for (int i = 0; i < STORE_DEPTH; i++) color_store[i] = '0;
    phase_q = PH_IDLE;
    tick_q = '0;
    bit_q = '0;
    pix_q = '0;
    line_q = 1'b0;
    regs_q.bit_period = RST_BIT_PERIOD;
    regs_q.zero_high = RST_ZERO_HIGH;
    regs_q.one_high = RST_ONE_HIGH;
    regs_q.guard = RST_GUARD;
    regs_q.pixel_count = RST_PIXEL_COUNT;
    line_states_due.delete();
  endtask

  task automatic write_reg(logic [aled_pkg::CFG_AW-1:0] addr, logic [31:0] data);
    case (addr[4:2])
      REG_BIT_PERIOD:  regs_q.bit_period = data[11:0];
      REG_ZERO_HIGH:   regs_q.zero_high = data[11:0];
      REG_ONE_HIGH:    regs_q.one_high = data[11:0];
      REG_GUARD:       regs_q.guard = data[15:0];
      REG_PIXEL_COUNT: regs_q.pixel_count = data[6:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] reg_value(logic [aled_pkg::CFG_AW-1:0] addr);
    case (addr[4:2])
      REG_BIT_PERIOD:  return {20'd0, regs_q.bit_period};
      REG_ZERO_HIGH:   return {20'd0, regs_q.zero_high};
      REG_ONE_HIGH:    return {20'd0, regs_q.one_high};
      REG_GUARD:       return {16'd0, regs_q.guard};
      REG_PIXEL_COUNT: return {25'd0, regs_q.pixel_count};
      default:         return '0;
    endcase
  endfunction

  function automatic res_t strip_step(kind_t kind, logic [5:0] idx, logic [7:0] g,
                                      logic [7:0] r, logic [7:0] b);
    res_t        res;
    logic        bit_val;
    int unsigned high_len;
    int unsigned period_len;
    int unsigned guard_len;
    int unsigned span;
    res.accepted = 1'b1;
    res.frame_done = 1'b0;
    case (kind)
      KIND_SET: color_store[idx] = {g, r, b};
      KIND_CLEAR: color_store[idx] = '0;
      KIND_START: begin
        if (phase_q != PH_IDLE) begin
          res.accepted = 1'b0;
        end else begin
          phase_q = PH_SEND;
          tick_q = '0;
          bit_q = '0;
          pix_q = '0;
        end
      end
      default: begin
        if (phase_q == PH_SEND) begin
          bit_val = color_store[pix_q][PIXEL_BITS - 1 - bit_q];
          high_len = bit_val ? regs_q.one_high : regs_q.zero_high;
          period_len = (regs_q.bit_period == 0) ? 1 : regs_q.bit_period;
          line_q = (tick_q < high_len);
          tick_q = tick_q + 16'd1;
          if (tick_q >= period_len) begin
            tick_q = '0;
            if (bit_q == PIXEL_BITS - 1) begin
              bit_q = '0;
              span = (regs_q.pixel_count == 0) ? 1 :
                     (regs_q.pixel_count > STORE_DEPTH) ? STORE_DEPTH : regs_q.pixel_count;
              if (pix_q + 1 >= span) begin
                pix_q = '0;
                phase_q = PH_GUARD;
              end else begin
                pix_q = pix_q + 6'd1;
              end
            end else begin
              bit_q = bit_q + 5'd1;
            end
          end
        end else if (phase_q == PH_GUARD) begin
          guard_len = (regs_q.guard == 0) ? 1 : regs_q.guard;
          line_q = 1'b0;
          tick_q = tick_q + 16'd1;
          if (tick_q >= guard_len) begin
            tick_q = '0;
            phase_q = PH_IDLE;
            res.frame_done = 1'b1;
          end
        end else begin
          line_q = 1'b0;
        end
      end
    endcase
    res.line_level = line_q;
    res.busy_res = (phase_q != PH_IDLE);
    return res;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      clear_model();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          write_reg(cfg_paddr, cfg_pwdata);
        end else if (cfg_prdata !== reg_value(cfg_paddr)) begin
          report_mismatch("register read", cfg_prdata, reg_value(cfg_paddr));
        end
      end
      if (out_valid && !out_stall) begin
        got = {out_line_level, out_busy_res, out_accepted, out_frame_done};
        if (line_states_due.size() == 0) begin
          report_mismatch("result with no item waiting", got, '0);
        end else begin
          want = line_states_due.pop_front();
          if (got.line_level !== want.line_level)
            report_mismatch("line_level", got.line_level, want.line_level);
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
          if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
          if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", got.frame_done, want.frame_done);
        end
      end
      if (in_valid && !in_stall) begin
        want = strip_step(kind_t'(in_kind), in_pixel_index, in_green, in_red, in_blue);
        if (want.frame_done) frames_latched++;
        line_states_due.push_back(want);
      end
    end
    waiting_cnt = line_states_due.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the LED strip serial encoder testbench: clock, reset, item and register stimulus,
// and the verdict. Depends on aled_pkg, the encoder RTL and led_line_checker.
module tb;
  import aled_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_kind;
  logic [5:0]          in_pixel_index;
  logic [7:0]          in_green;
  logic [7:0]          in_red;
  logic [7:0]          in_blue;
  logic                out_valid;
  logic                out_stall;
  logic                out_line_level;
  logic                out_busy_res;
  logic                out_accepted;
  logic                out_frame_done;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;
  int                  fail_cnt;
  int                  waiting_cnt;
  int                  frames_latched;
  int                  gap_pct;
  int                  stall_pct;
  int                  cycle_cnt;
  int                  settings_run;
  int                  sent_ticks;
  int                  sent_starts;
  int                  sent_writes;

  addressable_led_serial_encoder dut (.*);

  led_line_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send_item(kind_t kind, logic [5:0] idx, logic [7:0] g, logic [7:0] r,
                           logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_pixel_index <= idx;
    in_green <= g;
    in_red <= r;
    in_blue <= b;
    do @(posedge clk); while (in_stall);
    case (kind)
      KIND_TICK:  sent_ticks++;
      KIND_START: sent_starts++;
      default:    sent_writes++;
    endcase
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random(int tick_pct);
    int unsigned roll;
    int          spare;
    logic [5:0]  idx;
    roll = $urandom_range(99);
    spare = 100 - tick_pct;
    idx = ($urandom_range(1) != 0) ? 6'($urandom_range(3)) : 6'($urandom_range(63));
    if (roll < tick_pct)
      send_item(KIND_TICK, idx, pick_level(), pick_level(), pick_level());
    else if (roll < tick_pct + spare / 2)
      send_item(KIND_SET, idx, pick_level(), pick_level(), pick_level());
    else if (roll < tick_pct + spare / 2 + spare / 5)
      send_item(KIND_CLEAR, idx, pick_level(), pick_level(), pick_level());
    else
      send_item(KIND_START, idx, pick_level(), pick_level(), pick_level());
  endtask

  task automatic apb_access(logic wr, logic [2:0] idx, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic read_all_regs();
    apb_access(1'b0, REG_BIT_PERIOD, '0);
    apb_access(1'b0, REG_ZERO_HIGH, '0);
    apb_access(1'b0, REG_ONE_HIGH, '0);
    apb_access(1'b0, REG_GUARD, '0);
    apb_access(1'b0, REG_PIXEL_COUNT, '0);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apply_regs(int bp, int zh, int oh, int gd, int pc);
    apb_access(1'b1, REG_BIT_PERIOD, bp);
    apb_access(1'b1, REG_ZERO_HIGH, zh);
    apb_access(1'b1, REG_ONE_HIGH, oh);
    apb_access(1'b1, REG_GUARD, gd);
    apb_access(1'b1, REG_PIXEL_COUNT, pc);
    read_all_regs();
    settings_run++;
  endtask

  // The sender holds off until every result of the items sent so far is back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting_cnt != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic run_phase(int bp, int zh, int oh, int gd, int pc, int gap, int stall,
                           int tick_pct, int items);
    settle();
    apply_regs(bp, zh, oh, gd, pc);
    gap_pct = gap;
    stall_pct = stall;
    repeat (items) send_random(tick_pct);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_SET;
    in_pixel_index = '0;
    in_green = '0;
    in_red = '0;
    in_blue = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    gap_pct = 0;
    stall_pct = 0;
    cycle_cnt = 0;
    settings_run = 0;
    sent_ticks = 0;
    sent_starts = 0;
    sent_writes = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_all_regs();

    // A tick before any start leaves the line low; the second start is refused,
    // and the rewrite of pixel 0 lands while its bits are being sent.
    apply_regs(4, 1, 3, 2, 2);
    stall_pct = 58;
    send_item(KIND_TICK, 6'd0, 8'hFF, 8'hFF, 8'hFF);
    send_item(KIND_SET, 6'd0, 8'hFF, 8'h00, 8'hFF);
    send_item(KIND_SET, 6'd63, 8'h00, 8'hFF, 8'h00);
    send_item(KIND_SET, 6'd1, 8'hA5, 8'h5A, 8'h3C);
    send_item(KIND_CLEAR, 6'd63, 8'hFF, 8'hFF, 8'hFF);
    send_item(KIND_START, 6'd0, 8'h00, 8'h00, 8'h00);
    send_item(KIND_START, 6'd63, 8'hFF, 8'hFF, 8'hFF);
    repeat (14) send_item(KIND_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
    send_item(KIND_SET, 6'd0, 8'h00, 8'hFF, 8'h00);
    repeat (4) send_item(KIND_TICK, 6'd63, 8'hFF, 8'hFF, 8'hFF);

    run_phase(3, 1, 2, 4, 2, 0, 0, 75, 100);
    run_phase(2, 1, 1, 1, 1, 58, 0, 75, 100);
    run_phase(0, 0, 4095, 0, 0, 0, 58, 80, 120);
    run_phase(4095, 4095, 1, 65535, 64, 20, 20, 80, 80);
    run_phase(2, 1, 3, 3, 1, 58, 0, 75, 100);
    run_phase(1, 0, 1, 0, 127, 20, 20, 93, 150);
    run_phase(5, 2, 4, 7, 3, 0, 58, 75, 100);
    run_phase(3, 3, 5, 2, 1, 0, 0, 75, 80);
    settle();
    repeat (4) @(posedge clk);

    $display("tb: %0d items over %0d register settings (%0d ticks, %0d starts, %0d pixel writes)",
             sent_ticks + sent_starts + sent_writes, settings_run, sent_ticks, sent_starts,
             sent_writes);
    $display("tb: %0d frames ran through their latch time", frames_latched);
    if (fail_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
